>>> src/multi_reader_broadcast_ring_top_defines.svh
// ----------------------------------------------------------------------------
// multi_reader_broadcast_ring_top_defines.svh
// assertion macros of the broadcast ring rtl
// ----------------------------------------------------------------------------
`ifndef MULTI_READER_BROADCAST_RING_TOP_DEFINES_SVH
`define MULTI_READER_BROADCAST_RING_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MRBR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mrbr assertion failed");

// next-cycle implication, disabled during reset
`define MRBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mrbr assertion failed");

`endif

>>> src/mrbr_pkg.sv
// ----------------------------------------------------------------------------
// mrbr_pkg
// shared constants, types and index helpers of the broadcast ring
// ----------------------------------------------------------------------------
package mrbr_pkg;

    // sizing
    localparam int DEPTH        = 64;
    localparam int READERS      = 32;
    localparam int PAYLOAD_BITS = 64;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int LEN_W        = 7;
    localparam int CNT_W        = 6;
    localparam int RID_W        = 5;

    // operation codes
    localparam logic [2:0] OP_PUT      = 3'd0;
    localparam logic [2:0] OP_RETRIEVE = 3'd1;
    localparam logic [2:0] OP_CLEAR    = 3'd2;
    localparam logic [2:0] OP_COUNT    = 3'd3;
    localparam logic [2:0] OP_POP      = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // configuration register indexes
    localparam logic CFG_RING_LENGTH = 1'b0;
    localparam logic CFG_READER_MASK = 1'b1;

    // write control toward the entry store
    typedef struct packed {
        logic             bits_en;
        logic             pay_en;
        logic [IDX_W-1:0] addr;
    } mrbr_wr_t;

    // ring length in use, out-of-range values act as the full depth
    function automatic logic [LEN_W:0] len_eff(input logic [LEN_W-1:0] len);
        logic [LEN_W:0] res;
        if (len < LEN_W'(2) || 32'(len) > DEPTH)
            res = (LEN_W+1)'(DEPTH);
        else
            res = {1'b0, len};
        return res;
    endfunction

    // next index modulo the ring length in use
    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx,
                                                   input logic [LEN_W:0] len);
        logic [IDX_W-1:0] res;
        if ((LEN_W+1)'(idx) + (LEN_W+1)'(1) == len)
            res = '0;
        else
            res = idx + IDX_W'(1);
        return res;
    endfunction

endpackage

>>> src/mrbr_mem.sv
// ----------------------------------------------------------------------------
// mrbr_mem
// entry store: payload and reader bitmap per slot, one write and one read port
// ----------------------------------------------------------------------------
module mrbr_mem
    import mrbr_pkg::*;
(
    input  logic                    clk,
    input  mrbr_wr_t                wr,
    input  logic [READERS-1:0]      wr_bits,
    input  logic [PAYLOAD_BITS-1:0] wr_pay,
    input  logic [IDX_W-1:0]        rd_addr,
    output logic [READERS-1:0]      rd_bits,
    output logic [PAYLOAD_BITS-1:0] rd_pay
);

    logic [READERS-1:0]      bits_mem [DEPTH];
    logic [PAYLOAD_BITS-1:0] pay_mem  [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.bits_en)
        begin
            bits_mem[wr.addr] <= wr_bits;
        end
        if (wr.pay_en)
        begin
            pay_mem[wr.addr] <= wr_pay;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_bits <= bits_mem[rd_addr];
        rd_pay  <= pay_mem[rd_addr];
    end

endmodule

>>> src/multi_reader_broadcast_ring_top.sv
// ----------------------------------------------------------------------------
// multi_reader_broadcast_ring_top
// circular notification queue whose entries are delivered to several readers
// ----------------------------------------------------------------------------
// Items arrive on the s_ channel: tuser carries the operation, tdata the
// payload and reader id. Each item gives one result on the m_ channel.
// Configuration writes (ring length, reader mask) come on the cfg_ channel;
// the user must issue them only while the block is idle, which the block
// itself does not enforce. A ring length write empties the ring. Put and pop
// need no scan of the entry store. Retrieve, clear and count walk the live
// entries through the single read port of the entry store, one entry per
// cycle. The next item is accepted once the result sits in the output
// register. Reset empties the ring and sets length 64 and an empty reader
// mask; the entry store is not cleared. A stalled receiver holds the result
// in the output register; the block finishes the next item and then waits
// until the register frees.
// ----------------------------------------------------------------------------
`include "multi_reader_broadcast_ring_top_defines.svh"

module multi_reader_broadcast_ring_top
    import mrbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // payload_in[63:0], reader_id[68:64], zero
    input  logic [2:0]  s_tuser,   // op[2:0]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // payload_out[63:0], pending_count[69:64],
                                   // is_full[70], is_empty[71]
    output logic [1:0]  m_tuser,   // status[1:0]
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [IDX_W-1:0]        head_reg, head_next;
    logic [IDX_W-1:0]        tail_reg, tail_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [READERS-1:0]      mask_reg, mask_next;
    logic [2:0]              op_reg, op_next;
    logic [RID_W-1:0]        rid_reg, rid_next;
    logic [IDX_W-1:0]        iss_ptr_reg, iss_ptr_next;
    logic                    iss_on_reg, iss_on_next;
    logic                    chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]        chk_ptr_reg, chk_ptr_next;
    logic                    chk_last_reg, chk_last_next;
    logic [1:0]              status_reg, status_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [PAYLOAD_BITS-1:0] pout_reg, pout_next;
    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              out_status_reg, out_status_next;
    logic [CNT_W-1:0]        out_cnt_reg, out_cnt_next;
    logic                    out_full_reg, out_full_next;
    logic                    out_empty_reg, out_empty_next;
    logic [PAYLOAD_BITS-1:0] out_pay_reg, out_pay_next;

    logic [LEN_W:0]          len_cur;
    logic                    ring_empty;
    logic                    ring_full;
    logic                    in_accept;
    logic [2:0]              in_op;
    logic [RID_W-1:0]        in_rid;
    logic [PAYLOAD_BITS-1:0] in_pay;
    logic                    in_rid_ok;
    logic [READERS-1:0]      rbit;
    logic                    hit;
    logic [READERS-1:0]      bits_cleared;
    mrbr_wr_t                wr;
    logic [READERS-1:0]      wr_bits;
    logic [PAYLOAD_BITS-1:0] wr_pay;
    logic [READERS-1:0]      rd_bits;
    logic [PAYLOAD_BITS-1:0] rd_pay;

    // entry store
    mrbr_mem u_mem (
        .clk     (clk),
        .wr      (wr),
        .wr_bits (wr_bits),
        .wr_pay  (wr_pay),
        .rd_addr (iss_ptr_reg),
        .rd_bits (rd_bits),
        .rd_pay  (rd_pay)
    );

    // port unpacking and ring flags
    assign in_op        = s_tuser;
    assign in_pay       = s_tdata[PAYLOAD_BITS-1:0];
    assign in_rid       = s_tdata[68:64];
    assign in_accept    = s_tvalid && s_tready;
    assign in_rid_ok    = 32'(in_rid) < READERS;
    assign len_cur      = len_eff(len_reg);
    assign ring_empty   = head_reg == tail_reg;
    assign ring_full    = idx_next(tail_reg, len_cur) == head_reg;
    assign rbit         = READERS'(1) << rid_reg;
    assign hit          = |(rd_bits & rbit);
    assign bits_cleared = rd_bits & ~rbit;

    assign s_tready  = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_status_reg;
    assign m_tdata   = {out_empty_reg, out_full_reg, out_cnt_reg,
                        64'(out_pay_reg)};

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        len_next        = len_reg;
        mask_next       = mask_reg;
        op_next         = op_reg;
        rid_next        = rid_reg;
        iss_ptr_next    = iss_ptr_reg;
        iss_on_next     = iss_on_reg;
        chk_valid_next  = 1'b0;
        chk_ptr_next    = chk_ptr_reg;
        chk_last_next   = chk_last_reg;
        status_next     = status_reg;
        cnt_next        = cnt_reg;
        pout_next       = pout_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_cnt_next    = out_cnt_reg;
        out_full_next   = out_full_reg;
        out_empty_next  = out_empty_reg;
        out_pay_next    = out_pay_reg;
        wr              = '0;
        wr_bits         = bits_cleared;
        wr_pay          = in_pay;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next     = in_op;
                    rid_next    = in_rid;
                    status_next = STAT_OK;
                    cnt_next    = '0;
                    pout_next   = '0;
                    state_next  = ST_FIN;
                    case (in_op)
                        OP_PUT:
                        begin
                            if (ring_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                wr.bits_en = 1'b1;
                                wr.pay_en  = 1'b1;
                                wr.addr    = idx_next(tail_reg, len_cur);
                                wr_bits    = mask_reg;
                                tail_next  = idx_next(tail_reg, len_cur);
                            end
                        end
                        OP_RETRIEVE, OP_CLEAR, OP_COUNT:
                        begin
                            if (ring_empty || !in_rid_ok)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                status_next  = (in_op == OP_RETRIEVE) ? STAT_EMPTY : STAT_OK;
                                iss_ptr_next = idx_next(head_reg, len_cur);
                                iss_on_next  = 1'b1;
                                state_next   = ST_SCAN;
                            end
                        end
                        OP_POP:
                        begin
                            if (ring_empty)
                                status_next = STAT_EMPTY;
                            else
                                head_next = idx_next(head_reg, len_cur);
                        end
                        default:
                        begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // issue one read per cycle from oldest toward newest
                if (iss_on_reg)
                begin
                    chk_valid_next = 1'b1;
                    chk_ptr_next   = iss_ptr_reg;
                    chk_last_next  = iss_ptr_reg == tail_reg;
                    iss_ptr_next   = idx_next(iss_ptr_reg, len_cur);
                    iss_on_next    = iss_ptr_reg != tail_reg;
                end
                // check the entry read in the previous cycle
                if (chk_valid_reg)
                begin
                    case (op_reg)
                        OP_RETRIEVE:
                        begin
                            if (hit)
                            begin
                                wr.bits_en     = 1'b1;
                                wr.addr        = chk_ptr_reg;
                                pout_next      = rd_pay;
                                status_next    = STAT_OK;
                                if (bits_cleared == '0)
                                    head_next = idx_next(head_reg, len_cur);
                                iss_on_next    = 1'b0;
                                chk_valid_next = 1'b0;
                                state_next     = ST_FIN;
                            end
                            else if (chk_last_reg)
                            begin
                                state_next = ST_FIN;
                            end
                        end
                        OP_CLEAR:
                        begin
                            wr.bits_en = 1'b1;
                            wr.addr    = chk_ptr_reg;
                            if (chk_last_reg)
                                state_next = ST_FIN;
                        end
                        default:
                        begin
                            if (hit && cnt_reg != '1)
                                cnt_next = cnt_reg + CNT_W'(1);
                            if (chk_last_reg)
                                state_next = ST_FIN;
                        end
                    endcase
                end
            end

            ST_FIN:
            begin
                // load the output register once it is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_cnt_next    = cnt_reg;
                    out_pay_next    = pout_reg;
                    out_full_next   = ring_full;
                    out_empty_next  = ring_empty;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // configuration writes
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RING_LENGTH:
                begin
                    len_next  = cfg_data[LEN_W-1:0];
                    head_next = '0;
                    tail_next = '0;
                end
                default:
                begin
                    mask_next = cfg_data[READERS-1:0];
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            len_reg       <= LEN_W'(64);
            mask_reg      <= '0;
            iss_on_reg    <= 1'b0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            len_reg       <= len_next;
            mask_reg      <= mask_next;
            iss_on_reg    <= iss_on_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        rid_reg        <= rid_next;
        iss_ptr_reg    <= iss_ptr_next;
        chk_ptr_reg    <= chk_ptr_next;
        chk_last_reg   <= chk_last_next;
        status_reg     <= status_next;
        cnt_reg        <= cnt_next;
        pout_reg       <= pout_next;
        out_status_reg <= out_status_next;
        out_cnt_reg    <= out_cnt_next;
        out_full_reg   <= out_full_next;
        out_empty_reg  <= out_empty_next;
        out_pay_reg    <= out_pay_next;
    end

    // checks
    `MRBR_ASSERT_NOW(a_not_full_and_empty, clk, rst_n, 1'b1, !(ring_full && ring_empty))
    `MRBR_ASSERT_NOW(a_head_in_ring, clk, rst_n, 1'b1, (LEN_W+1)'(head_reg) < len_cur)
    `MRBR_ASSERT_NOW(a_tail_in_ring, clk, rst_n, 1'b1, (LEN_W+1)'(tail_reg) < len_cur)
    `MRBR_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_accept, state_reg != ST_IDLE)
    `MRBR_ASSERT_NOW(a_scan_only_on_nonempty, clk, rst_n,
        state_reg == ST_SCAN && chk_valid_reg && op_reg == OP_COUNT, !ring_empty)

endmodule
